[hw/rtl/icp_pkg.sv]
// Shared types and constants for the inter-robot collision potential block.
`timescale 1ns / 1ps
package icp_pkg;

  localparam int DIST_W    = 16;
  localparam int GAIN_W    = 16;
  localparam int GAIN_FRAC = 8;
  localparam int OUT_W     = 32;
  localparam int OUT_FRAC  = 16;
  localparam int SQ_W      = 2 * DIST_W;
  localparam int KSQ_W     = GAIN_W + SQ_W;
  localparam int PROD_W    = KSQ_W + DIST_W;
  localparam int NUM_W     = PROD_W + OUT_FRAC;
  localparam int DEN_W     = PROD_W + 1;
  localparam int QUO_W     = OUT_W;
  localparam int HI_W      = NUM_W - QUO_W;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AVOID   = 3'd0,
    CFG_DESIRED = 3'd1,
    CFG_NEIGH   = 3'd2,
    CFG_GAIN_NR = 3'd3,
    CFG_GAIN_FR = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic             vld;
    logic             tag;
    logic             ovf;
    logic [QUO_W-1:0] quo;
  } div_res_t;

endpackage

[hw/rtl/icp_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with overflow detect.
`timescale 1ns / 1ps
module icp_div
  import icp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             in_vld,
  input  logic             in_tag,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output div_res_t         res
);

  logic [DEN_W-1:0] rem_r [0:QUO_W];
  logic [QUO_W-1:0] lo_r  [0:QUO_W];
  logic [QUO_W-1:0] q_r   [0:QUO_W];
  logic [DEN_W-1:0] den_r [0:QUO_W];
  logic             ovf_r [0:QUO_W];
  logic             tag_r [0:QUO_W];
  logic             vld_r [0:QUO_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= {{(DEN_W-HI_W){1'b0}}, num[NUM_W-1:QUO_W]};
      lo_r[0]  <= num[QUO_W-1:0];
      q_r[0]   <= '0;
      den_r[0] <= den;
      ovf_r[0] <= (den == '0) || ({{(DEN_W-HI_W){1'b0}}, num[NUM_W-1:QUO_W]} >= den);
      tag_r[0] <= in_tag;
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    logic [DEN_W:0]   sh;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [DEN_W-1:0] rem_nxt;

    assign sh      = {rem_r[k], lo_r[k][QUO_W-1]};
    assign diff    = sh - {1'b0, den_r[k]};
    assign ge      = sh >= {1'b0, den_r[k]};
    assign rem_nxt = ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (adv) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k+1] <= rem_nxt;
        lo_r[k+1]  <= {lo_r[k][QUO_W-2:0], 1'b0};
        q_r[k+1]   <= {q_r[k][QUO_W-2:0], ge};
        den_r[k+1] <= den_r[k];
        ovf_r[k+1] <= ovf_r[k];
        tag_r[k+1] <= tag_r[k];
      end
    end
  end

  assign res.vld = vld_r[QUO_W];
  assign res.tag = tag_r[QUO_W];
  assign res.ovf = ovf_r[QUO_W];
  assign res.quo = q_r[QUO_W];

`ifndef SYNTHESIS
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[QUO_W] && !ovf_r[QUO_W] |-> rem_r[QUO_W] < den_r[QUO_W])
    else $error("remainder not below divisor");
  a_den_held: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[QUO_W] && !ovf_r[QUO_W] |-> den_r[QUO_W] != '0)
    else $error("zero divisor not flagged");
  a_ovf_zero_den: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] && den_r[0] == '0 |-> ovf_r[0])
    else $error("zero divisor missed at entry");
`endif

endmodule

[hw/rtl/interrobot_collision_potential.sv]
// Top level of the inter-robot collision potential pipeline.
// Takes one distance word per cycle while in_ready is high and returns one potential
// word per distance, in order. The stages compute absolute differences, squares,
// products and denominator sums, then the two restoring dividers (one quotient bit per
// stage) and the output register. The whole pipeline holds while a finished word waits at
// the output. Write the registers only while no word is in flight.
`timescale 1ns / 1ps
module interrobot_collision_potential
  import icp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [DIST_W-1:0]    in_distance,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OUT_W-1:0]     out_potential,
  output logic                 out_saturated
);

  logic [DIST_W-1:0] avoid_r, desired_r, neigh_r;
  logic [GAIN_W-1:0] gain_nr_r, gain_fr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avoid_r   <= 16'd256;
      desired_r <= 16'd768;
      neigh_r   <= 16'd1280;
      gain_nr_r <= 16'd256;
      gain_fr_r <= 16'd256;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_AVOID:   avoid_r   <= cfg_wdata;
        CFG_DESIRED: desired_r <= cfg_wdata;
        CFG_NEIGH:   neigh_r   <= cfg_wdata;
        CFG_GAIN_NR: gain_nr_r <= cfg_wdata;
        CFG_GAIN_FR: gain_fr_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic adv;
  logic out_vld_r;
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic b1_r, b2_r, b3_r, b4_r, b5_r;

  assign adv      = !out_vld_r || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      {v1_r, v2_r, v3_r, v4_r, v5_r} <= '0;
    end else if (adv) begin
      {v1_r, v2_r, v3_r, v4_r, v5_r} <= {in_valid, v1_r, v2_r, v3_r, v4_r};
    end
  end

  logic [DIST_W-1:0] zd1_r, dr1_r, nz1_r, zr1_r, nr1_r;
  logic [SQ_W-1:0]   zd2_r, nr2_r, dr2_r;
  logic [DIST_W-1:0] nz2_r, zr2_r, nz3_r, zr3_r;
  logic [KSQ_W-1:0]  kzn3_r, kzf3_r, knn3_r, knf3_r, dnz3_r, dzr3_r, dnz4_r, dzr4_r;
  logic [PROD_W-1:0] nnum4_r, fnum4_r, nden4_r, fden4_r, nnum5_r, fnum5_r;
  logic [DEN_W-1:0]  nden5_r, fden5_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_r  <= (in_distance >= avoid_r) && (in_distance <= neigh_r);
      zd1_r <= (in_distance >= desired_r) ? in_distance - desired_r : desired_r - in_distance;
      dr1_r <= (desired_r >= avoid_r) ? desired_r - avoid_r : avoid_r - desired_r;
      nz1_r <= neigh_r - in_distance;
      zr1_r <= in_distance - avoid_r;
      nr1_r <= neigh_r - avoid_r;

      b2_r  <= b1_r;
      zd2_r <= SQ_W'(zd1_r) * SQ_W'(zd1_r);
      nr2_r <= SQ_W'(nr1_r) * SQ_W'(nr1_r);
      dr2_r <= SQ_W'(dr1_r) * SQ_W'(dr1_r);
      nz2_r <= nz1_r;
      zr2_r <= zr1_r;

      b3_r   <= b2_r;
      kzn3_r <= KSQ_W'(gain_nr_r) * KSQ_W'(zd2_r);
      kzf3_r <= KSQ_W'(gain_fr_r) * KSQ_W'(zd2_r);
      knn3_r <= KSQ_W'(gain_nr_r) * KSQ_W'(nr2_r);
      knf3_r <= KSQ_W'(gain_fr_r) * KSQ_W'(nr2_r);
      dnz3_r <= KSQ_W'(dr2_r) * KSQ_W'(nz2_r);
      dzr3_r <= KSQ_W'(dr2_r) * KSQ_W'(zr2_r);
      nz3_r  <= nz2_r;
      zr3_r  <= zr2_r;

      b4_r    <= b3_r;
      nnum4_r <= PROD_W'(kzn3_r) * PROD_W'(nz3_r);
      fnum4_r <= PROD_W'(kzf3_r) * PROD_W'(zr3_r);
      nden4_r <= PROD_W'(knn3_r) * PROD_W'(zr3_r);
      fden4_r <= PROD_W'(knf3_r) * PROD_W'(nz3_r);
      dnz4_r  <= dnz3_r;
      dzr4_r  <= dzr3_r;

      b5_r    <= b4_r;
      nnum5_r <= nnum4_r;
      fnum5_r <= fnum4_r;
      nden5_r <= DEN_W'(nden4_r) + DEN_W'({dnz4_r, {GAIN_FRAC{1'b0}}});
      fden5_r <= DEN_W'(fden4_r) + DEN_W'({dzr4_r, {GAIN_FRAC{1'b0}}});
    end
  end

  div_res_t near_res, far_res;

  icp_div u_div_near (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .in_vld (v5_r),
    .in_tag (b5_r),
    .num    ({nnum5_r, {OUT_FRAC{1'b0}}}),
    .den    (nden5_r),
    .res    (near_res)
  );

  icp_div u_div_far (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .in_vld (v5_r),
    .in_tag (b5_r),
    .num    ({fnum5_r, {OUT_FRAC{1'b0}}}),
    .den    (fden5_r),
    .res    (far_res)
  );

  logic [OUT_W:0]   sum;
  logic             sat_nxt;
  logic [OUT_W-1:0] pot_nxt;
  logic [OUT_W-1:0] pot_r;
  logic             sat_r;

  assign sum     = {1'b0, near_res.quo} + {1'b0, far_res.quo};
  assign sat_nxt = near_res.tag && (near_res.ovf || far_res.ovf || sum[OUT_W]);
  assign pot_nxt = !near_res.tag ? '0 : (sat_nxt ? '1 : sum[OUT_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= near_res.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pot_r <= pot_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_potential = pot_r;
  assign out_saturated = sat_r;

`ifndef SYNTHESIS
  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    near_res.vld == far_res.vld)
    else $error("dividers out of step");
  a_tag_match: assert property (@(posedge clk) disable iff (!rst_n)
    near_res.vld |-> near_res.tag == far_res.tag)
    else $error("band flag differs between dividers");
  a_sat_ones: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && sat_r |-> pot_r == '1)
    else $error("saturated word not all ones");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v5_r) && $stable(near_res.vld))
    else $error("pipeline moved during stall");
`endif

endmodule
